FILE: sv/point_cloud_xyz_extractor_core_macros.svh
// Assertion macros shared by the point cloud xyz extractor RTL.
`ifndef POINT_CLOUD_XYZ_EXTRACTOR_CORE_MACROS_SVH
`define POINT_CLOUD_XYZ_EXTRACTOR_CORE_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define PCX_ASSERT_IMPLY(label, clk_s, rstn_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define PCX_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/pcx_pkg.sv
// Shared types and constants of the point cloud xyz extractor.
`default_nettype none
package pcx_pkg;

	localparam int MAX_DATA_BYTES  = 16777216;
	localparam int MAX_POINT_BYTES = 256;
	localparam int DATA_CNT_W      = $clog2(MAX_DATA_BYTES + 2);
	localparam int QUEUE_DEPTH     = 4;
	localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 24;

	typedef enum logic [1:0] {
		ST_RUNNING,
		ST_OK,
		ST_BAD_LAYOUT,
		ST_LEN_MISMATCH
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_X_OFFSET,
		CFG_Y_OFFSET,
		CFG_Z_OFFSET,
		CFG_POINT_BYTES,
		CFG_ROW_BYTES,
		CFG_POINTS_PER_ROW,
		CFG_ROW_COUNT,
		CFG_DATA_LENGTH
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0]  x_offset;
		logic [7:0]  y_offset;
		logic [7:0]  z_offset;
		logic [7:0]  point_bytes;
		logic [23:0] row_bytes;
		logic [15:0] points_per_row;
		logic [15:0] row_count;
		logic [23:0] data_length;
	} cfg_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] sel;
	} lane_t;

	typedef struct packed {
		logic [7:0] data;
		lane_t      x_lane;
		lane_t      y_lane;
		lane_t      z_lane;
		logic       pt_end;
		logic       last;
		status_t    status;
	} entry_t;

endpackage
`default_nettype wire

FILE: sv/pcx_front.sv
// Front end: accepts data bytes, tracks the position in the cloud and classifies each byte.
`default_nettype none
module pcx_front (
	input  wire               clk,
	input  wire               arst_n,
	input  pcx_pkg::cfg_t     cfg,
	input  wire               cfg_we,
	input  wire               s_tvalid,
	output logic              s_tready,
	input  wire  [7:0]        s_tdata,
	input  wire               s_tlast,
	input  wire               q_full,
	output logic              push,
	output pcx_pkg::entry_t   push_entry
);
	import pcx_pkg::*;

	logic [7:0]            bip_q, bip_nx, bip_inc;
	logic [15:0]           pir_q, pir_nx;
	logic [23:0]           bir_q, bir_nx, bir_inc;
	logic [15:0]           rows_q, rows_nx;
	logic [DATA_CNT_W-1:0] seen_q, seen_nx;
	logic                  ok_q, cfg_pend_q;
	logic                  layout_ok, active, in_pts, pt_end, row_end, mismatch;
	logic [23:0]           prod_pr;
	logic [39:0]           prod_rc;

	function automatic lane_t lane_of(logic [7:0] pos, logic [7:0] off);
		lane_t      l;
		logic [7:0] diff;
		diff  = pos - off;
		l.hit = (pos >= off) && (diff <= 8'd3);
		l.sel = diff[1:0];
		return l;
	endfunction

	always_comb begin
		prod_pr   = 24'(cfg.point_bytes) * 24'(cfg.points_per_row);
		prod_rc   = 40'(cfg.row_bytes) * 40'(cfg.row_count);
		layout_ok = (cfg.point_bytes != 8'd0)
			&& (32'(cfg.point_bytes) <= MAX_POINT_BYTES)
			&& ({1'b0, cfg.x_offset} + 9'd4 <= {1'b0, cfg.point_bytes})
			&& ({1'b0, cfg.y_offset} + 9'd4 <= {1'b0, cfg.point_bytes})
			&& ({1'b0, cfg.z_offset} + 9'd4 <= {1'b0, cfg.point_bytes})
			&& (prod_pr <= cfg.row_bytes)
			&& (prod_rc <= 40'(cfg.data_length));
	end

	// The layout check is registered, so input is held off for one cycle after a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q       <= 1'b0;
			cfg_pend_q <= 1'b1;
		end else begin
			ok_q       <= layout_ok;
			cfg_pend_q <= cfg_we;
		end
	end

	assign s_tready = !q_full && !cfg_pend_q;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		seen_nx  = (seen_q <= DATA_CNT_W'(MAX_DATA_BYTES)) ? seen_q + 1'b1 : seen_q;
		active   = ok_q && (cfg.row_bytes != 24'd0) && (rows_q < cfg.row_count);
		in_pts   = pir_q < cfg.points_per_row;
		bip_inc  = bip_q + 8'd1;
		bir_inc  = bir_q + 24'd1;
		pt_end   = active && in_pts && (bip_inc >= cfg.point_bytes);
		row_end  = active && (bir_inc >= cfg.row_bytes);
		mismatch = (32'(cfg.data_length) > MAX_DATA_BYTES)
			|| (seen_nx != DATA_CNT_W'(cfg.data_length));

		push_entry.data   = s_tdata;
		push_entry.pt_end = pt_end;
		push_entry.last   = s_tlast;
		if (active && in_pts) begin
			push_entry.x_lane = lane_of(bip_q, cfg.x_offset);
			push_entry.y_lane = lane_of(bip_q, cfg.y_offset);
			push_entry.z_lane = lane_of(bip_q, cfg.z_offset);
		end else begin
			push_entry.x_lane = '0;
			push_entry.y_lane = '0;
			push_entry.z_lane = '0;
		end
		if (!s_tlast) begin
			push_entry.status = ST_RUNNING;
		end else if (mismatch) begin
			push_entry.status = ST_LEN_MISMATCH;
		end else if (!ok_q) begin
			push_entry.status = ST_BAD_LAYOUT;
		end else begin
			push_entry.status = ST_OK;
		end

		bip_nx  = bip_q;
		pir_nx  = pir_q;
		bir_nx  = bir_q;
		rows_nx = rows_q;
		if (active) begin
			if (in_pts) begin
				bip_nx = pt_end ? 8'd0 : bip_inc;
				pir_nx = pt_end ? pir_q + 16'd1 : pir_q;
			end
			bir_nx = row_end ? 24'd0 : bir_inc;
			if (row_end) begin
				pir_nx  = 16'd0;
				bip_nx  = 8'd0;
				rows_nx = rows_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bip_q  <= '0;
			pir_q  <= '0;
			bir_q  <= '0;
			rows_q <= '0;
			seen_q <= '0;
		end else if (push) begin
			if (s_tlast) begin
				bip_q  <= '0;
				pir_q  <= '0;
				bir_q  <= '0;
				rows_q <= '0;
				seen_q <= '0;
			end else begin
				bip_q  <= bip_nx;
				pir_q  <= pir_nx;
				bir_q  <= bir_nx;
				rows_q <= rows_nx;
				seen_q <= seen_nx;
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/pcx_queue.sv
// Short queue of classified bytes between the front end and the back end.
`default_nettype none
module pcx_queue (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  pcx_pkg::entry_t   push_entry,
	input  wire               pop,
	output pcx_pkg::entry_t   head,
	output logic              head_valid,
	output logic              full
);
	import pcx_pkg::*;

	entry_t              slots_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q, rd_q;
	logic [QUEUE_AW:0]   cnt_q;

	assign head       = slots_q[rd_q];
	assign head_valid = cnt_q != '0;
	assign full       = cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: sv/pcx_back.sv
// Back end: assembles the xyz words, checks them for finiteness and drives the result register.
`default_nettype none
`include "point_cloud_xyz_extractor_core_macros.svh"
module pcx_back (
	input  wire               clk,
	input  wire               arst_n,
	input  pcx_pkg::entry_t   head,
	input  wire               head_valid,
	output logic              pop,
	output logic              m_tvalid,
	input  wire               m_tready,
	output logic [95:0]       m_tdata,
	output logic              m_tlast,
	output logic [7:0]        m_tuser
);
	import pcx_pkg::*;

	logic [31:0] x_q, y_q, z_q;
	logic [31:0] x_nx, y_nx, z_nx;
	logic        has_pt, emit;

	function automatic logic [31:0] put_lane(logic [31:0] w, lane_t l, logic [7:0] b);
		logic [31:0] r;
		r = w;
		if (l.hit) begin
			r[{l.sel, 3'b000} +: 8] = b;
		end
		return r;
	endfunction

	function automatic logic finite32(logic [31:0] w);
		return w[30:23] != 8'hFF;
	endfunction

	always_comb begin
		x_nx   = put_lane(x_q, head.x_lane, head.data);
		y_nx   = put_lane(y_q, head.y_lane, head.data);
		z_nx   = put_lane(z_q, head.z_lane, head.data);
		has_pt = head.pt_end && finite32(x_nx) && finite32(y_nx) && finite32(z_nx);
		emit   = has_pt || head.last;
		pop    = head_valid && (!m_tvalid || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
		end else if (pop) begin
			x_q <= head.last ? '0 : x_nx;
			y_q <= head.last ? '0 : y_nx;
			z_q <= head.last ? '0 : z_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (pop && emit) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			m_tdata <= has_pt ? {z_nx, y_nx, x_nx} : '0;
			m_tlast <= head.last;
			m_tuser <= {5'd0, head.status, has_pt};
		end
	end

	`PCX_ASSERT_IMPLY(a_empty_words, clk, arst_n, m_tvalid && !m_tuser[0], m_tdata == '0, "words set without a point")
	`PCX_ASSERT_IMPLY(a_status_done, clk, arst_n, m_tvalid && !m_tlast, m_tuser[2:1] == ST_RUNNING, "status before last byte")
	`PCX_ASSERT_IMPLY(a_useful, clk, arst_n, m_tvalid, m_tuser[0] || m_tlast, "empty result transfer")
	`PCX_ASSERT_NEXT(a_emit_shown, clk, arst_n, pop && emit, m_tvalid, "result lost")

endmodule
`default_nettype wire

FILE: sv/point_cloud_xyz_extractor_core.sv
// Top level of the point cloud xyz extractor: configuration registers and the front/back split.
//
// Channel  Dir  Signals                         Contents
// s        in   s_tvalid s_tready s_tdata s_tlast  data byte, last byte of the area
// m        out  m_tvalid m_tready m_tdata m_tlast  x/y/z words, closing result
//                m_tuser                           point flag and status
// cfg      in   cfg_we cfg_index cfg_data          register writes
//
// One byte transfer per cycle is sustained while the queue has room and no write settles.
// The front end updates the position counters in the cycle of the transfer, and the back
// end assembles the words from the queue head and loads the output register on its pop.
// s_tready drops for one cycle after each register write while the layout check settles.
// A four-entry queue lets the front keep taking bytes while a result waits on m_tready.
// Reset is asynchronous and needs no clearing pass.
`default_nettype none
module point_cloud_xyz_extractor_core (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire  [7:0]                        s_tdata,   // [7:0] data_byte
	input  wire                               s_tlast,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [95:0]                       m_tdata,   // [31:0] x, [63:32] y, [95:64] z
	output logic                              m_tlast,
	output logic [7:0]                        m_tuser,   // [0] has_point, [2:1] status
	input  wire                               cfg_we,
	input  wire  [pcx_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [pcx_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import pcx_pkg::*;

	cfg_t   cfg_q;
	entry_t push_entry, head;
	logic   push, pop, head_valid, q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_offset       <= 8'd0;
			cfg_q.y_offset       <= 8'd4;
			cfg_q.z_offset       <= 8'd8;
			cfg_q.point_bytes    <= 8'd16;
			cfg_q.row_bytes      <= '0;
			cfg_q.points_per_row <= '0;
			cfg_q.row_count      <= '0;
			cfg_q.data_length    <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_X_OFFSET:       cfg_q.x_offset       <= cfg_data[7:0];
				CFG_Y_OFFSET:       cfg_q.y_offset       <= cfg_data[7:0];
				CFG_Z_OFFSET:       cfg_q.z_offset       <= cfg_data[7:0];
				CFG_POINT_BYTES:    cfg_q.point_bytes    <= cfg_data[7:0];
				CFG_ROW_BYTES:      cfg_q.row_bytes      <= cfg_data[23:0];
				CFG_POINTS_PER_ROW: cfg_q.points_per_row <= cfg_data[15:0];
				CFG_ROW_COUNT:      cfg_q.row_count      <= cfg_data[15:0];
				CFG_DATA_LENGTH:    cfg_q.data_length    <= cfg_data[23:0];
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	pcx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cfg_we     (cfg_we),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	pcx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (q_full)
	);

	pcx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule
`default_nettype wire

FILE: test/point_cloud_xyz_extractor_core_tb.sv
// Self-checking testbench for the point cloud xyz extractor core with random layouts and stalls.
`timescale 1ns / 1ps
module point_cloud_xyz_extractor_core_tb;
	import pcx_pkg::*;

	localparam int STUCK_LIMIT  = 500;
	localparam int SETTLE_LEN   = 6;
	localparam int RANDOM_BYTES = 550;

	typedef struct {
		bit          has_point;
		bit [31:0]   x_bits;
		bit [31:0]   y_bits;
		bit [31:0]   z_bits;
		bit          done_res;
		status_t     status;
	} point_result_t;

	class cloud_scoreboard;
		cfg_t            layout;
		bit [7:0]        byte_in_point;
		bit [15:0]       point_in_row;
		bit [23:0]       byte_in_row;
		bit [15:0]       rows_done;
		int unsigned     bytes_seen;
		bit [31:0]       x_word;
		bit [31:0]       y_word;
		bit [31:0]       z_word;
		point_result_t   pending_results[$];
		int              errors;

		function new();
			layout = '0;
			layout.y_offset = 8'd4;
			layout.z_offset = 8'd8;
			layout.point_bytes = 8'd16;
			errors = 0;
			clear_stream();
		endfunction

		function void clear_stream();
			byte_in_point = '0;
			point_in_row = '0;
			byte_in_row = '0;
			rows_done = '0;
			bytes_seen = 0;
			x_word = '0;
			y_word = '0;
			z_word = '0;
		endfunction

		function void write_reg(cfg_idx_t idx, bit [23:0] value);
			case (idx)
				CFG_X_OFFSET: layout.x_offset = value[7:0];
				CFG_Y_OFFSET: layout.y_offset = value[7:0];
				CFG_Z_OFFSET: layout.z_offset = value[7:0];
				CFG_POINT_BYTES: layout.point_bytes = value[7:0];
				CFG_ROW_BYTES: layout.row_bytes = value;
				CFG_POINTS_PER_ROW: layout.points_per_row = value[15:0];
				CFG_ROW_COUNT: layout.row_count = value[15:0];
				CFG_DATA_LENGTH: layout.data_length = value;
				default: ;
			endcase
		endfunction

		function bit layout_valid();
			longint unsigned pb;
			pb = layout.point_bytes;
			if (pb == 0 || pb > MAX_POINT_BYTES)
				return 0;
			if (64'(layout.x_offset) + 4 > pb || 64'(layout.y_offset) + 4 > pb ||
					64'(layout.z_offset) + 4 > pb)
				return 0;
			if (pb * 64'(layout.points_per_row) > 64'(layout.row_bytes))
				return 0;
			if (64'(layout.row_bytes) * 64'(layout.row_count) > 64'(layout.data_length))
				return 0;
			return 1;
		endfunction

		// A byte lands in a word only when it falls in the four bytes at the word's offset.
		function bit [31:0] place_byte(bit [31:0] word, bit [7:0] pos, bit [7:0] off,
				bit [7:0] b);
			if (pos < off || pos - off > 3)
				return word;
			word[(pos - off) * 8 +: 8] = b;
			return word;
		endfunction

		function void note_byte(bit [7:0] b, bit last);
			bit            ok;
			bit            pt;
			point_result_t r;
			ok = layout_valid();
			pt = 0;
			if (bytes_seen <= MAX_DATA_BYTES)
				bytes_seen++;
			if (ok && layout.row_bytes != 0 && rows_done < layout.row_count) begin
				if (point_in_row < layout.points_per_row) begin
					x_word = place_byte(x_word, byte_in_point, layout.x_offset, b);
					y_word = place_byte(y_word, byte_in_point, layout.y_offset, b);
					z_word = place_byte(z_word, byte_in_point, layout.z_offset, b);
					byte_in_point++;
					if (byte_in_point >= layout.point_bytes) begin
						byte_in_point = '0;
						point_in_row++;
						pt = x_word[30:23] != 8'hFF && y_word[30:23] != 8'hFF &&
							z_word[30:23] != 8'hFF;
					end
				end
				byte_in_row++;
				if (byte_in_row >= layout.row_bytes) begin
					byte_in_row = '0;
					point_in_row = '0;
					byte_in_point = '0;
					rows_done++;
				end
			end
			if (!pt && !last)
				return;
			r.has_point = pt;
			r.x_bits = pt ? x_word : '0;
			r.y_bits = pt ? y_word : '0;
			r.z_bits = pt ? z_word : '0;
			r.done_res = last;
			if (!last)
				r.status = ST_RUNNING;
			else if (bytes_seen != layout.data_length)
				r.status = ST_LEN_MISMATCH;
			else if (!ok)
				r.status = ST_BAD_LAYOUT;
			else
				r.status = ST_OK;
			pending_results.insert(pending_results.size(), r);
			if (last)
				clear_stream();
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, actual %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [95:0] data, logic last, logic [7:0] user);
			point_result_t r;
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected: tdata %h", data);
				errors++;
				return;
			end
			r = pending_results.pop_front();
			check_field("has_point", 32'(r.has_point), 32'(user[0]));
			check_field("x_bits", r.x_bits, data[31:0]);
			check_field("y_bits", r.y_bits, data[63:32]);
			check_field("z_bits", r.z_bits, data[95:64]);
			check_field("done_res", 32'(r.done_res), 32'(last));
			check_field("status", 32'(r.status), 32'(user[2:1]));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [95:0]          m_tdata;
	logic                 m_tlast;
	logic [7:0]           m_tuser;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	cloud_scoreboard sb;
	bit              idle_on = 1'b1;
	int              stuck_cycles = 0;
	int              sink_hold = 0;

	point_cloud_xyz_extractor_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial sb = new();

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tlast, m_tuser);
		if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			sink_hold <= $urandom_range(0, 2);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		while (stuck_cycles < STUCK_LIMIT)
			@(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	// Writes every register of the layout, one per cycle, while the input side is idle.
	task automatic load_layout(cfg_t c);
		cfg_idx_t    idx;
		bit [23:0]   value;
		idx = idx.first();
		do begin
			case (idx)
				CFG_X_OFFSET: value = 24'(c.x_offset);
				CFG_Y_OFFSET: value = 24'(c.y_offset);
				CFG_Z_OFFSET: value = 24'(c.z_offset);
				CFG_POINT_BYTES: value = 24'(c.point_bytes);
				CFG_ROW_BYTES: value = c.row_bytes;
				CFG_POINTS_PER_ROW: value = 24'(c.points_per_row);
				CFG_ROW_COUNT: value = 24'(c.row_count);
				default: value = c.data_length;
			endcase
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= value;
			@(posedge clk);
			sb.write_reg(idx, value);
			idx = idx.next();
		end while (idx != idx.first());
		cfg_we <= 1'b0;
	endtask

	task automatic send_cloud(bit [7:0] data[$]);
		for (int i = 0; i < data.size(); i++) begin
			if (idle_on && $urandom_range(0, 4) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= data[i];
			s_tlast <= (i == data.size() - 1);
			do @(posedge clk); while (!s_tready);
			sb.note_byte(data[i], i == data.size() - 1);
		end
		s_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_LEN) @(posedge clk);
	endtask

	function automatic void pick_layout(output cfg_t c, output int unsigned nbytes);
		int unsigned pb;
		int unsigned ppr;
		int unsigned rb;
		int unsigned rc;
		pb = ($urandom_range(0, 24) == 0) ? 255 : $urandom_range(4, 20);
		ppr = (pb > 64) ? 1 : $urandom_range(1, 3);
		rc = (pb > 64) ? 1 : $urandom_range(1, 2);
		rb = pb * ppr + $urandom_range(0, 3);
		c.x_offset = 8'($urandom_range(0, pb - 4));
		c.y_offset = 8'($urandom_range(0, pb - 4));
		c.z_offset = 8'($urandom_range(0, pb - 4));
		c.point_bytes = 8'(pb);
		c.points_per_row = 16'(ppr);
		c.row_bytes = 24'(rb);
		c.row_count = 16'(rc);
		c.data_length = 24'(rb * rc + $urandom_range(0, 4));
		if ($urandom_range(0, 99) >= 75) begin
			case ($urandom_range(0, 8))
				0: c.x_offset = 8'($urandom_range(pb - 3, 255));
				1: c.point_bytes = 8'd0;
				2: c.row_bytes = 24'(pb * ppr - 1);
				3: c.data_length = 24'(rb * rc - 1);
				4: c.row_bytes = 24'd0;
				5: c.row_count = 16'd0;
				6: begin
					c.points_per_row = 16'hFFFF;
					c.row_count = 16'hFFFF;
					c.row_bytes = 24'hFFFFFF;
					c.data_length = 24'hFFFFFF;
				end
				7: begin
					c.points_per_row = 16'd1;
					c.row_count = 16'd1;
					c.row_bytes = 24'hFFFFFF;
					c.data_length = 24'hFFFFFF;
				end
				default: begin
					c.point_bytes = 8'hFF;
					c.x_offset = 8'hFF;
					c.y_offset = 8'hFF;
					c.z_offset = 8'hFF;
				end
			endcase
		end
		nbytes = c.data_length;
		if (nbytes > 1200)
			nbytes = $urandom_range(1, 100);
		else if ($urandom_range(0, 7) == 0)
			nbytes = nbytes + $urandom_range(0, 2) - 1;
		if (nbytes == 0)
			nbytes = 1;
	endfunction

	// Special byte values make non-finite exponents common enough to drop points often.
	function automatic bit [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h7F;
			3: return 8'h80;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		cfg_t        c;
		bit [7:0]    data[$];
		int unsigned nbytes;
		int          random_bytes;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With the reset layout, a single byte cannot match a zero data length.
		send_cloud('{8'hFF});

		c = '0;
		c.point_bytes = 8'd4;
		c.points_per_row = 16'd1;
		c.row_bytes = 24'd4;
		c.row_count = 16'd2;
		c.data_length = 24'd8;
		load_layout(c);
		send_cloud('{8'h00, 8'h00, 8'h80, 8'h3F, 8'h00, 8'h00, 8'h80, 8'h7F});

		c.row_count = 16'd1;
		c.data_length = 24'd4;
		load_layout(c);
		send_cloud('{8'h01, 8'h02, 8'h03, 8'h04});

		c.point_bytes = 8'd0;
		c.data_length = 24'd1;
		load_layout(c);
		send_cloud('{8'h5A});

		random_bytes = 0;
		while (random_bytes < RANDOM_BYTES) begin
			idle_on = (random_bytes < RANDOM_BYTES - 100);
			pick_layout(c, nbytes);
			load_layout(c);
			data.delete();
			repeat (nbytes) data.insert(data.size(), pick_byte());
			send_cloud(data);
			random_bytes += nbytes;
		end

		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/pcx_pkg.sv
sv/pcx_front.sv
sv/pcx_queue.sv
sv/pcx_back.sv
sv/point_cloud_xyz_extractor_core.sv
test/point_cloud_xyz_extractor_core_tb.sv
